>>> rtl/get_pkg.sv
// shared types and constants for the gabriel edge test block
// no dependencies
`default_nettype none
package get_pkg;

  localparam int PT_W = 6;
  localparam int DIM_W = 3;
  localparam int IN_FEAT_W = 16;
  localparam int LBL_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;
  localparam int ACT_PTS_W = 7;
  localparam int ACT_DIMS_W = 4;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_MAX_DIMS = 8;
  localparam int DEF_FEATURE_WIDTH = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DIMS = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                        cmd;
    logic [PT_W-1:0]             point_a;
    logic [PT_W-1:0]             point_b;
    logic [DIM_W-1:0]            dim_index;
    logic signed [IN_FEAT_W-1:0] feature_value;
    logic [LBL_W-1:0]            cluster_label;
  } in_word_t;

  typedef struct packed {
    logic [PT_W-1:0] first_point;
    logic [PT_W-1:0] second_point;
    logic            is_edge;
    logic            crosses_clusters;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tok_ctl_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } hit_t;

endpackage
`default_nettype wire

>>> rtl/get_cell.sv
// one point cell: holds a point's features, squares 2k-a-b per dimension
// uses get_pkg
`default_nettype none
module get_cell #(
  parameter int MAX_DIMS = 8,
  parameter int FW = 16,
  parameter int AW = 39,
  parameter int DIW = 3,
  parameter int APW = 7,
  parameter int CELL_ID = 0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          ld_we,
  input  wire [get_pkg::PT_W-1:0]      ld_point,
  input  wire [DIW-1:0]                ld_dim,
  input  wire signed [FW-1:0]          ld_data,
  input  wire [get_pkg::PT_W-1:0]      q_a,
  input  wire [get_pkg::PT_W-1:0]      q_b,
  input  wire [APW-1:0]                act,
  input  wire [AW-1:0]                 radius,
  input  get_pkg::tok_ctl_t            tok_in,
  input  wire [DIW-1:0]                dim_in,
  input  wire signed [FW:0]            s_in,
  input  get_pkg::hit_t                hit_in,
  output get_pkg::tok_ctl_t            tok_out,
  output logic [DIW-1:0]               dim_out,
  output logic signed [FW:0]           s_out,
  output get_pkg::hit_t                hit_out
);
  import get_pkg::*;

  logic signed [FW-1:0]    feat_r [MAX_DIMS];
  tok_ctl_t                tok_r, v1_r, v2_r;
  logic [DIW-1:0]          dim_r;
  logic signed [FW:0]      s_r;
  logic signed [FW+1:0]    t1_r;
  logic [2*FW+3:0]         sq2_r;
  logic [AW-1:0]           acc_r;
  hit_t                    hit_r;
  logic signed [FW-1:0]    f_sel;
  logic signed [FW+1:0]    t_nxt;
  logic signed [2*FW+3:0]  prod;
  logic [AW-1:0]           sum;
  logic                    en;

  always_comb begin
    f_sel = feat_r[dim_in];
    t_nxt = $signed({f_sel[FW-1], f_sel, 1'b0}) - $signed({s_in[FW], s_in});
    prod = t1_r * t1_r;
    sum = (v2_r.first ? '0 : acc_r) + AW'(sq2_r);
    en = (CELL_ID < int'(act)) && (CELL_ID != int'(q_a)) && (CELL_ID != int'(q_b));
  end

  always_ff @(posedge clk) begin
    if (ld_we && int'(ld_point) == CELL_ID) begin
      feat_r[ld_dim] <= ld_data;
    end
    dim_r <= dim_in;
    s_r <= s_in;
    t1_r <= t_nxt;
    sq2_r <= prod;
    if (v2_r.valid) begin
      acc_r <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      v1_r <= '0;
      v2_r <= '0;
      hit_r <= '0;
    end else begin
      tok_r <= tok_in;
      v1_r <= tok_in;
      v2_r <= v1_r;
      hit_r.valid <= v2_r.valid && v2_r.last;
      hit_r.hit <= hit_in.hit | (en && (sum < radius));
    end
  end

  assign tok_out = tok_r;
  assign dim_out = dim_r;
  assign s_out = s_r;
  assign hit_out = hit_r;

endmodule
`default_nettype wire

>>> rtl/get_seq.sv
// query sequencer: config registers, feature and label memories, radius, token issue
// uses get_pkg
`default_nettype none
module get_seq #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS = 8,
  parameter int FW = 16,
  parameter int AW = 39,
  parameter int DIW = 3,
  parameter int APW = 7
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  get_pkg::in_word_t            in_word,
  input  wire                          cfg_we,
  input  wire [get_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [get_pkg::CFG_DATA_W-1:0] cfg_data,
  input  get_pkg::hit_t                chain_hit,
  output logic                         busy,
  output logic                         ld_we,
  output logic [DIW-1:0]               ld_dim,
  output logic signed [FW-1:0]         ld_data,
  output logic [get_pkg::PT_W-1:0]     q_a,
  output logic [get_pkg::PT_W-1:0]     q_b,
  output logic [APW-1:0]               act,
  output logic [AW-1:0]                radius,
  output get_pkg::tok_ctl_t            tok,
  output logic [DIW-1:0]               tok_dim,
  output logic signed [FW:0]           tok_s,
  output logic                         out_valid,
  output get_pkg::out_word_t           out_word
);
  import get_pkg::*;

  localparam int PIW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int MAW = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int DW = $clog2(MAX_DIMS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ISS1 = 3'd1;
  localparam logic [2:0] ST_WT1 = 3'd2;
  localparam logic [2:0] ST_ISS2 = 3'd3;
  localparam logic [2:0] ST_WT2 = 3'd4;
  localparam logic [2:0] ST_FIN = 3'd5;

  logic signed [FW-1:0] fmem [MAX_POINTS*MAX_DIMS];
  logic [LBL_W-1:0]     lmem [MAX_POINTS];

  logic [2:0]           state_r, state_nxt;
  logic [APW-1:0]       act_r;
  logic [DW-1:0]        dims_r;
  logic [DW-1:0]        cnt_r, cnt_nxt;
  logic [PT_W-1:0]      qa_r, qb_r;
  logic                 inr_r, edge_r, edge_nxt;
  logic [LBL_W-1:0]     la_r, lb_r;
  logic signed [FW-1:0] fa_r, fb_r;
  tok_ctl_t             rd_r, v2_r, v3_r, tok_r;
  logic                 rd_p2_r;
  logic [DIW-1:0]       rd_dim_r, tok_dim_r;
  logic signed [FW:0]   diff_r, tok_s_r;
  logic [2*FW+1:0]      sq_r;
  logic [AW-1:0]        rad_r;
  logic [MAW-1:0]       addr_a, addr_b, addr_w;
  logic                 accept, q_acc, issue, iss_last, inr, vpair;
  logic signed [2*FW+1:0] dprod;

  always_comb begin
    accept = start && (state_r == ST_IDLE);
    q_acc = accept && (in_word.cmd == CMD_QUERY);
    ld_we = accept && (in_word.cmd == CMD_LOAD) && (int'(in_word.point_a) < MAX_POINTS)
            && (int'(in_word.dim_index) < MAX_DIMS);
    ld_dim = DIW'(in_word.dim_index);
    ld_data = FW'(in_word.feature_value);
    inr = (int'(in_word.point_a) < MAX_POINTS) && (int'(in_word.point_b) < MAX_POINTS);
    vpair = inr && (in_word.point_a != in_word.point_b)
            && (int'(in_word.point_a) < int'(act_r)) && (int'(in_word.point_b) < int'(act_r));
    issue = (state_r == ST_ISS1) || (state_r == ST_ISS2);
    iss_last = (cnt_r == dims_r - DW'(1));
    addr_w = MAW'(PIW'(in_word.point_a)) * MAW'(MAX_DIMS) + MAW'(ld_dim);
    addr_a = MAW'(PIW'(qa_r)) * MAW'(MAX_DIMS) + MAW'(cnt_r[DIW-1:0]);
    addr_b = MAW'(PIW'(qb_r)) * MAW'(MAX_DIMS) + MAW'(cnt_r[DIW-1:0]);
    dprod = diff_r * diff_r;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    edge_nxt = edge_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (q_acc) begin
          if (!vpair) begin
            edge_nxt = 1'b0;
            state_nxt = ST_FIN;
          end else if (dims_r == '0) begin
            edge_nxt = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_ISS1;
          end
        end
      end
      ST_ISS1: begin
        cnt_nxt = cnt_r + DW'(1);
        if (iss_last) begin
          state_nxt = ST_WT1;
        end
      end
      ST_WT1: begin
        cnt_nxt = '0;
        if (!rd_r.valid && !v2_r.valid && !v3_r.valid) begin
          state_nxt = ST_ISS2;
        end
      end
      ST_ISS2: begin
        cnt_nxt = cnt_r + DW'(1);
        if (iss_last) begin
          state_nxt = ST_WT2;
        end
      end
      ST_WT2: begin
        if (chain_hit.valid) begin
          edge_nxt = !chain_hit.hit;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      fmem[addr_w] <= ld_data;
      lmem[PIW'(in_word.point_a)] <= in_word.cluster_label;
    end
    fa_r <= fmem[addr_a];
    fb_r <= fmem[addr_b];
    if (q_acc) begin
      la_r <= lmem[PIW'(in_word.point_a)];
      lb_r <= lmem[PIW'(in_word.point_b)];
      qa_r <= in_word.point_a;
      qb_r <= in_word.point_b;
      inr_r <= inr;
    end
    rd_dim_r <= cnt_r[DIW-1:0];
    rd_p2_r <= (state_r == ST_ISS2);
    diff_r <= $signed({fa_r[FW-1], fa_r}) - $signed({fb_r[FW-1], fb_r});
    sq_r <= dprod;
    tok_s_r <= $signed({fa_r[FW-1], fa_r}) + $signed({fb_r[FW-1], fb_r});
    tok_dim_r <= rd_dim_r;
    edge_r <= edge_nxt;
    if (q_acc) begin
      rad_r <= '0;
    end else if (v3_r.valid) begin
      rad_r <= rad_r + AW'(sq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      act_r <= '0;
      dims_r <= DW'(1);
      rd_r <= '0;
      v2_r <= '0;
      v3_r <= '0;
      tok_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we && cfg_index == CFG_ACTIVE_POINTS) begin
        act_r <= (int'(cfg_data) > MAX_POINTS) ? APW'(MAX_POINTS) : APW'(cfg_data);
      end
      if (cfg_we && cfg_index == CFG_ACTIVE_DIMS) begin
        dims_r <= (int'(cfg_data[ACT_DIMS_W-1:0]) > MAX_DIMS) ? DW'(MAX_DIMS)
                  : DW'(cfg_data[ACT_DIMS_W-1:0]);
      end
      rd_r.valid <= issue;
      rd_r.first <= (cnt_r == '0);
      rd_r.last <= iss_last;
      v2_r <= rd_p2_r ? '0 : rd_r;
      v3_r <= v2_r;
      tok_r <= rd_p2_r ? rd_r : '0;
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign q_a = qa_r;
  assign q_b = qb_r;
  assign act = act_r;
  assign radius = rad_r;
  assign tok = tok_r;
  assign tok_dim = tok_dim_r;
  assign tok_s = tok_s_r;
  assign out_valid = (state_r == ST_FIN);
  assign out_word.first_point = qa_r;
  assign out_word.second_point = qb_r;
  assign out_word.is_edge = edge_r;
  assign out_word.crosses_clusters = inr_r && (la_r != lb_r);

endmodule
`default_nettype wire

>>> rtl/gabriel_edge_test.sv
// gabriel edge test top: sequencer plus a row of MAX_POINTS point cells
// uses get_pkg, get_seq, get_cell
// load: busy stays low; query: result after two dim passes plus the cell row walk, next start
// accepted in the cycle after the result; stores are undefined until loaded
// invalid pair or zero active dims: result in the cycle after accept; receiver cannot stall
// synchronous active-low reset clears control and active points and sets active dims to 1
`default_nettype none
module gabriel_edge_test #(
  parameter int MAX_POINTS = get_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIMS = get_pkg::DEF_MAX_DIMS,
  parameter int FEATURE_WIDTH = get_pkg::DEF_FEATURE_WIDTH
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  get_pkg::in_word_t              in_word,
  input  wire                            cfg_we,
  input  wire [get_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [get_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                           out_valid,
  output get_pkg::out_word_t             out_word
);
  import get_pkg::*;

  localparam int FW = FEATURE_WIDTH;
  localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int APW = $clog2(MAX_POINTS + 1);
  localparam int AW = 2 * FW + 4 + DIW;

  logic                 ld_we;
  logic [DIW-1:0]       ld_dim;
  logic signed [FW-1:0] ld_data;
  logic [PT_W-1:0]      q_a, q_b;
  logic [APW-1:0]       act;
  logic [AW-1:0]        radius;
  tok_ctl_t             tok [MAX_POINTS+1];
  logic [DIW-1:0]       dim [MAX_POINTS+1];
  logic signed [FW:0]   s [MAX_POINTS+1];
  hit_t                 hit [MAX_POINTS+1];

  assign hit[0] = '0;

  get_seq #(
    .MAX_POINTS(MAX_POINTS), .MAX_DIMS(MAX_DIMS), .FW(FW), .AW(AW), .DIW(DIW), .APW(APW)
  ) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .chain_hit(hit[MAX_POINTS]), .busy(busy), .ld_we(ld_we), .ld_dim(ld_dim),
    .ld_data(ld_data), .q_a(q_a), .q_b(q_b), .act(act), .radius(radius),
    .tok(tok[0]), .tok_dim(dim[0]), .tok_s(s[0]),
    .out_valid(out_valid), .out_word(out_word)
  );

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    get_cell #(
      .MAX_DIMS(MAX_DIMS), .FW(FW), .AW(AW), .DIW(DIW), .APW(APW), .CELL_ID(k)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .ld_we(ld_we), .ld_point(in_word.point_a),
      .ld_dim(ld_dim), .ld_data(ld_data), .q_a(q_a), .q_b(q_b), .act(act),
      .radius(radius), .tok_in(tok[k]), .dim_in(dim[k]), .s_in(s[k]),
      .hit_in(hit[k]), .tok_out(tok[k+1]), .dim_out(dim[k+1]), .s_out(s[k+1]),
      .hit_out(hit[k+1])
    );
  end

endmodule
`default_nettype wire
